// File: rtl/fbmgn_pkg.sv
// ----------------------------------------------------------------------------
// fbmgn_pkg: shared types and constants of the fractal gradient noise block
// Holds field widths, hash constants, register indexes and pipeline items.
// ----------------------------------------------------------------------------
package fbmgn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;

    localparam int SUM_W  = 56;   // signed Q.30 weighted noise sum
    localparam int ASUM_W = 36;   // unsigned Q.14 amplitude sum
    localparam int GRAD_W = 20;   // signed Q.16 corner and blend values
    localparam int QUOT_W = 17;   // quotient magnitude bits
    localparam int CELL_LAT = 8;  // pipeline depth of one octave cell

    localparam logic [31:0] HASH_MUL_Y    = 32'd374761393;
    localparam logic [31:0] HASH_MUL_SEED = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;
    localparam logic [31:0] SEED_STEP     = 32'd17;

    localparam logic [31:0] AMP_START = 32'd16384;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_SEED   = 3'd0;
    localparam logic [2:0] REG_OCTAVE = 3'd1;
    localparam logic [2:0] REG_BASE   = 3'd2;
    localparam logic [2:0] REG_SCALE  = 3'd3;
    localparam logic [2:0] REG_GAIN   = 3'd4;
    localparam logic [2:0] REG_LACUN  = 3'd5;

    localparam logic [31:0] RST_SEED   = 32'd0;
    localparam logic [3:0]  RST_OCTAVE = 4'd4;
    localparam logic [31:0] RST_BASE   = 32'd167772;
    localparam logic [31:0] RST_SCALE  = 32'd16777216;
    localparam logic [15:0] RST_GAIN   = 16'd8192;
    localparam logic [15:0] RST_LACUN  = 16'd8192;

    // Work item handed from one octave cell to the next.
    typedef struct packed {
        logic signed [31:0]       px;
        logic signed [31:0]       py;
        logic [31:0]              freq;
        logic [31:0]              amp;
        logic [31:0]              seed;
        logic signed [SUM_W-1:0]  sum;
        logic [ASUM_W-1:0]        amp_sum;
    } t_item;

    // Work item of the quotient chain.
    typedef struct packed {
        logic [SUM_W-1:0]  rem;
        logic [SUM_W-1:0]  den;
        logic [QUOT_W-1:0] quo;
        logic              neg;
        logic              zero;
    } t_div;

endpackage

// File: rtl/fbmgn_cell.sv
// ----------------------------------------------------------------------------
// fbmgn_cell: one octave of gradient noise
// Scales the point, hashes the four lattice corners, fades and blends them,
// and, for an active octave, adds the weighted result to the running sum of the item.
// ----------------------------------------------------------------------------
module fbmgn_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  fbmgn_pkg::t_item     i_item,
    input  logic                 i_active,
    input  logic [15:0]          i_gain,
    input  logic [15:0]          i_lacun,
    output logic                 o_valid,
    output fbmgn_pkg::t_item     o_item
);

    localparam int GW = fbmgn_pkg::GRAD_W;
    localparam int SW = fbmgn_pkg::SUM_W;
    localparam int AW = fbmgn_pkg::ASUM_W;

    function automatic logic [19:0] fade_mul(input logic [19:0] r, input logic [15:0] t);
        logic [35:0] p;
        p = r * t;
        return p[35:16];
    endfunction

    function automatic logic [19:0] fade_first(input logic [15:0] t);
        logic [19:0] q;
        logic [35:0] p;
        q = 20'd983040 - 20'(20'(t) * 20'd6);
        p = q * t;
        return p[35:16];
    endfunction

    function automatic logic signed [GW-1:0] grad(input logic [2:0] s,
                                                   input logic signed [17:0] gx,
                                                   input logic signed [17:0] gy);
        logic signed [GW-1:0] x;
        logic signed [GW-1:0] y;
        x = GW'(gx);
        y = GW'(gy);
        case (s)
            3'd0:    return x + y;
            3'd1:    return y - x;
            3'd2:    return x - y;
            3'd3:    return -x - y;
            3'd4:    return x;
            3'd5:    return -x;
            3'd6:    return y;
            default: return -y;
        endcase
    endfunction

    function automatic logic signed [GW-1:0] blend(input logic signed [GW-1:0] a,
                                                    input logic signed [GW-1:0] b,
                                                    input logic [16:0] w);
        logic signed [GW:0]     d;
        logic signed [GW+18:0]  p;
        d = (GW+1)'(b) - (GW+1)'(a);
        p = d * $signed({1'b0, w});
        return a + GW'(p >>> 16);
    endfunction

    function automatic logic [31:0] hash_mix(input logic [31:0] x, input logic [31:0] yc,
                                             input logic [31:0] sd);
        logic [31:0] h;
        logic [63:0] p;
        h = x ^ yc ^ sd;
        h = h ^ (h >> 13);
        p = h * fbmgn_pkg::HASH_MUL_MIX;
        return p[31:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [35:0] v);
        return (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    logic [8:1]               r_v;
    logic [7:1]               r_act;
    fbmgn_pkg::t_item         r_it [1:8];
    logic [31:0]              r_ac [2:7];

    logic signed [64:0]       r1_px, r1_py;
    logic [47:0]              r1_fp, r1_ap;
    logic [31:0]              r1_sdm;

    logic [31:0]              r2_x0, r2_yc0, r2_yc1, r2_sdm;
    logic [15:0]              r2_fx, r2_fy;
    logic [19:0]              r2_qx, r2_qy;

    logic [31:0]              r3_hm [4];
    logic [15:0]              r3_fx, r3_fy;
    logic [19:0]              r3_rx, r3_ry;

    logic signed [GW-1:0]     r4_g [4];
    logic [15:0]              r4_fx, r4_fy;
    logic [19:0]              r4_rx, r4_ry;

    logic signed [GW-1:0]     r5_g [4];
    logic [16:0]              r5_u, r5_v;

    logic signed [GW-1:0]     r6_ab, r6_cd;
    logic [16:0]              r6_v;

    logic signed [GW-1:0]     r7_nz;

    // Combinational next values.
    logic [31:0]              n2_x0, n2_y0, n2_y1;
    logic [63:0]              n2_yc0, n2_yc1;
    logic [63:0]              n1_sdm;
    fbmgn_pkg::t_item         n2_it, n8_it;
    logic [2:0]               n4_sel [4];
    logic signed [17:0]       n4_gx0, n4_gx1, n4_gy0, n4_gy1;
    logic signed [52:0]       n8_wt;

    always_comb begin
        n1_sdm = i_item.seed * fbmgn_pkg::HASH_MUL_SEED;
        n2_x0  = {{4{r1_px[63]}}, r1_px[63:36]};
        n2_y0  = {{4{r1_py[63]}}, r1_py[63:36]};
        n2_y1  = n2_y0 + 32'd1;
        n2_yc0 = n2_y0 * fbmgn_pkg::HASH_MUL_Y;
        n2_yc1 = n2_y1 * fbmgn_pkg::HASH_MUL_Y;
        n2_it      = r_it[1];
        n2_it.freq = sat32(r1_fp[47:12]);
        n2_it.amp  = sat32({2'b00, r1_ap[47:14]});
        n2_it.seed = r_it[1].seed + fbmgn_pkg::SEED_STEP;
        for (int c = 0; c < 4; c++) begin
            n4_sel[c] = r3_hm[c][2:0] ^ r3_hm[c][18:16];
        end
        n4_gx0 = {2'b00, r3_fx};
        n4_gx1 = {2'b11, r3_fx};
        n4_gy0 = {2'b00, r3_fy};
        n4_gy1 = {2'b11, r3_fy};
        n8_wt  = r7_nz * $signed({1'b0, r_ac[7]});
        n8_it  = r_it[7];
        if (r_act[7]) begin
            n8_it.sum     = r_it[7].sum + SW'(n8_wt);
            n8_it.amp_sum = r_it[7].amp_sum + AW'(r_ac[7]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage 1: scale the point, step frequency and amplitude.
            r_it[1]  <= i_item;
            r_act[1] <= i_active;
            r1_px    <= i_item.px * $signed({1'b0, i_item.freq});
            r1_py    <= i_item.py * $signed({1'b0, i_item.freq});
            r1_fp    <= i_item.freq * i_lacun;
            r1_ap    <= i_item.amp * i_gain;
            r1_sdm   <= n1_sdm[31:0];
            // Stage 2: lattice cell, fraction, first fade product.
            r_it[2]  <= n2_it;
            r_ac[2]  <= r_it[1].amp;
            r_act[2] <= r_act[1];
            r2_x0    <= n2_x0;
            r2_yc0   <= n2_yc0[31:0];
            r2_yc1   <= n2_yc1[31:0];
            r2_sdm   <= r1_sdm;
            r2_fx    <= r1_px[35:20];
            r2_fy    <= r1_py[35:20];
            r2_qx    <= fade_first(r1_px[35:20]);
            r2_qy    <= fade_first(r1_py[35:20]);
            // Stage 3: corner hashes.
            r_it[3]  <= r_it[2];
            r_ac[3]  <= r_ac[2];
            r_act[3] <= r_act[2];
            r3_hm[0] <= hash_mix(r2_x0,         r2_yc0, r2_sdm);
            r3_hm[1] <= hash_mix(r2_x0 + 32'd1, r2_yc0, r2_sdm);
            r3_hm[2] <= hash_mix(r2_x0,         r2_yc1, r2_sdm);
            r3_hm[3] <= hash_mix(r2_x0 + 32'd1, r2_yc1, r2_sdm);
            r3_fx    <= r2_fx;
            r3_fy    <= r2_fy;
            r3_rx    <= fade_mul(20'd655360 - r2_qx, r2_fx);
            r3_ry    <= fade_mul(20'd655360 - r2_qy, r2_fy);
            // Stage 4: corner gradients.
            r_it[4]  <= r_it[3];
            r_ac[4]  <= r_ac[3];
            r_act[4] <= r_act[3];
            r4_g[0]  <= grad(n4_sel[0], n4_gx0, n4_gy0);
            r4_g[1]  <= grad(n4_sel[1], n4_gx1, n4_gy0);
            r4_g[2]  <= grad(n4_sel[2], n4_gx0, n4_gy1);
            r4_g[3]  <= grad(n4_sel[3], n4_gx1, n4_gy1);
            r4_fx    <= r3_fx;
            r4_fy    <= r3_fy;
            r4_rx    <= fade_mul(r3_rx, r3_fx);
            r4_ry    <= fade_mul(r3_ry, r3_fy);
            // Stage 5: last fade product.
            r_it[5]  <= r_it[4];
            r_ac[5]  <= r_ac[4];
            r_act[5] <= r_act[4];
            r5_g     <= r4_g;
            r5_u     <= 17'(fade_mul(r4_rx, r4_fx));
            r5_v     <= 17'(fade_mul(r4_ry, r4_fy));
            // Stage 6: blend along x.
            r_it[6]  <= r_it[5];
            r_ac[6]  <= r_ac[5];
            r_act[6] <= r_act[5];
            r6_ab    <= blend(r5_g[0], r5_g[1], r5_u);
            r6_cd    <= blend(r5_g[2], r5_g[3], r5_u);
            r6_v     <= r5_v;
            // Stage 7: blend along y.
            r_it[7]  <= r_it[6];
            r_ac[7]  <= r_ac[6];
            r_act[7] <= r_act[6];
            r7_nz    <= blend(r6_ab, r6_cd, r6_v);
            // Stage 8: accumulate.
            r_it[8]  <= n8_it;
        end
    end

    assign o_valid = r_v[8];
    assign o_item  = r_it[8];

endmodule

// File: rtl/fbmgn_div_stage.sv
// ----------------------------------------------------------------------------
// fbmgn_div_stage: one quotient bit of the normalizing division
// Subtracts the aligned divisor when it fits and halves it for the next bit.
// ----------------------------------------------------------------------------
module fbmgn_div_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  fbmgn_pkg::t_div   i_div,
    output logic              o_valid,
    output fbmgn_pkg::t_div   o_div
);

    logic            r_v;
    fbmgn_pkg::t_div r_div;
    fbmgn_pkg::t_div n_div;
    logic            w_fit;

    always_comb begin
        w_fit = (i_div.rem >= i_div.den);
        n_div = i_div;
        n_div.rem = w_fit ? (i_div.rem - i_div.den) : i_div.rem;
        n_div.quo = {i_div.quo[fbmgn_pkg::QUOT_W-2:0], w_fit};
        n_div.den = i_div.den >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_v;
    assign o_div   = r_div;

endmodule

// File: rtl/fbm_gradient_noise.sv
// ----------------------------------------------------------------------------
// fbm_gradient_noise: fractal 2D gradient noise, one point per unstalled cycle
// Top level: registers, front stage, octave cell chain, divider, output.
// ----------------------------------------------------------------------------
// Usage:
// Points arrive on the slave stream (point_x and point_y, signed Q20.12) and
// one noise value (signed Q1.15) leaves on the master stream per point.
// The block takes one transfer per clock cycle when the output side keeps up.
// The pipeline is made of the chain of octave cells (eight stages each, one
// cell per possible octave; unused octaves add nothing to the sums), two
// front stages, the divider setup register, a seventeen-stage restoring
// divider and the output register.
// Configuration is written through the plain write port while no point is in
// flight. Reset restores the default register values and empties the
// pipeline; there is no clearing pass.
// When the receiver stalls, the finished value waits in the output register
// and the pipeline keeps moving until a finished value reaches its last
// stage; only then does the whole pipeline, and the input ready, hold.
// ----------------------------------------------------------------------------
module fbm_gradient_noise #(
    parameter int MAX_OCTAVES = fbmgn_pkg::MAX_OCTAVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] point_x, [63:32] point_y
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] noise_value
);

    localparam int QW = fbmgn_pkg::QUOT_W;
    localparam int SW = fbmgn_pkg::SUM_W;

    // Configuration registers.
    logic [31:0] r_seed, r_base, r_scale;
    logic [3:0]  r_octaves;
    logic [15:0] r_gain, r_lacun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= fbmgn_pkg::RST_SEED;
            r_octaves <= fbmgn_pkg::RST_OCTAVE;
            r_base    <= fbmgn_pkg::RST_BASE;
            r_scale   <= fbmgn_pkg::RST_SCALE;
            r_gain    <= fbmgn_pkg::RST_GAIN;
            r_lacun   <= fbmgn_pkg::RST_LACUN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                fbmgn_pkg::REG_SEED:   r_seed    <= i_cfg_wdata;
                fbmgn_pkg::REG_OCTAVE: r_octaves <= i_cfg_wdata[3:0];
                fbmgn_pkg::REG_BASE:   r_base    <= i_cfg_wdata;
                fbmgn_pkg::REG_SCALE:  r_scale   <= i_cfg_wdata;
                fbmgn_pkg::REG_GAIN:   r_gain    <= i_cfg_wdata[15:0];
                fbmgn_pkg::REG_LACUN:  r_lacun   <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together. It holds only when a finished value
    // sits in the last divider stage and the output register cannot take it.
    logic w_en;
    logic r_out_v;
    logic w_last_v;

    assign w_en       = !(r_out_v && !i_m_tready && w_last_v);
    assign o_s_tready = w_en;

    // Front: first octave frequency is base times scale in Q8.24.
    logic               r_f1_v, r_f2_v;
    logic signed [31:0] r_f1_px, r_f1_py;
    logic [63:0]        r_f1_prod;
    fbmgn_pkg::t_item   r_f2_it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= i_s_tvalid;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_px   <= i_s_tdata[31:0];
            r_f1_py   <= i_s_tdata[63:32];
            r_f1_prod <= r_base * r_scale;
            r_f2_it.px      <= r_f1_px;
            r_f2_it.py      <= r_f1_py;
            r_f2_it.freq    <= (r_f1_prod[63:56] != 8'd0) ? 32'hFFFF_FFFF : r_f1_prod[55:24];
            r_f2_it.amp     <= fbmgn_pkg::AMP_START;
            r_f2_it.seed    <= r_seed;
            r_f2_it.sum     <= '0;
            r_f2_it.amp_sum <= '0;
        end
    end

    // Octave cell chain. Cells past the octave count leave the sum and amplitude sum unchanged.
    fbmgn_pkg::t_item w_it [MAX_OCTAVES+1];
    logic [MAX_OCTAVES:0] w_it_v;

    assign w_it[0]   = r_f2_it;
    assign w_it_v[0] = r_f2_v;

    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
        logic w_active;
        assign w_active = (5'(k) < {1'b0, r_octaves});
        fbmgn_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_it_v[k]),
            .i_item   (w_it[k]),
            .i_active (w_active),
            .i_gain   (r_gain),
            .i_lacun  (r_lacun),
            .o_valid  (w_it_v[k+1]),
            .o_item   (w_it[k+1])
        );
    end

    // Divider setup: magnitude of the sum over twice the amplitude sum,
    // divisor aligned to the top quotient bit.
    logic             r_d0_v;
    fbmgn_pkg::t_div  r_d0;
    fbmgn_pkg::t_item w_last_it;

    assign w_last_it = w_it[MAX_OCTAVES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_v <= 1'b0;
        end else if (w_en) begin
            r_d0_v <= w_it_v[MAX_OCTAVES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0.neg  <= w_last_it.sum[SW-1];
            r_d0.rem  <= w_last_it.sum[SW-1] ? SW'(-w_last_it.sum) : SW'(w_last_it.sum);
            r_d0.den  <= SW'({w_last_it.amp_sum, 1'b0}) << (QW - 1);
            r_d0.quo  <= '0;
            r_d0.zero <= (w_last_it.amp_sum == '0);
        end
    end

    fbmgn_pkg::t_div w_dv [QW+1];
    logic [QW:0]     w_dv_v;

    assign w_dv[0]   = r_d0;
    assign w_dv_v[0] = r_d0_v;

    for (genvar b = 0; b < QW; b++) begin : g_div
        fbmgn_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[b]),
            .i_div   (w_dv[b]),
            .o_valid (w_dv_v[b+1]),
            .o_div   (w_dv[b+1])
        );
    end

    assign w_last_v = w_dv_v[QW];

    // Sign, saturation and the zero-octave case.
    fbmgn_pkg::t_div w_q;
    logic [15:0]     n_out;

    assign w_q = w_dv[QW];

    always_comb begin
        if (w_q.zero) begin
            n_out = 16'd0;
        end else if (w_q.neg) begin
            n_out = (w_q.quo > QW'(32768)) ? 16'h8000 : 16'(-w_q.quo);
        end else begin
            n_out = (w_q.quo > QW'(32767)) ? 16'h7FFF : w_q.quo[15:0];
        end
    end

    logic [15:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            r_out_v <= w_last_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_out_v || i_m_tready) && w_last_v) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;

endmodule
